// ----- src/polyline_proximity_test_defines.svh -----
// Assertion helpers used by the RTL
`ifndef POLYLINE_PROXIMITY_TEST_DEFINES_SVH
`define POLYLINE_PROXIMITY_TEST_DEFINES_SVH

// same-cycle implication
`define PPT_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PPT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/ppt_pkg.sv -----
package ppt_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int VIDX_W       = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int LAT_W        = 28;
  localparam int LON_W        = 29;
  localparam int THR_W        = 29;
  localparam int SQ_W         = 59;
  localparam int N_W          = 60;
  localparam int ACC_W        = 122;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_QUERY  = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    PH_T  = 3'd0,
    PH_D2 = 3'd1,
    PH_M  = 3'd2,
    PH_N  = 3'd3,
    PH_E  = 3'd4,
    PH_W  = 3'd5
  } phase_t;

  typedef struct packed {
    logic        valid;
    logic        clr;
    logic        neg;
    logic [1:0]  shift;
    logic [31:0] a;
    logic [31:0] b;
  } mac_op_t;

endpackage

// ----- src/ppt_vertex_store.sv -----
module ppt_vertex_store (
  input  logic                                clk,
  input  logic                                wr_en,
  input  logic [ppt_pkg::VIDX_W-1:0]          wr_addr,
  input  logic signed [ppt_pkg::LAT_W-1:0]    wr_lat,
  input  logic signed [ppt_pkg::LON_W-1:0]    wr_lon,
  input  logic                                rd_en,
  input  logic [ppt_pkg::VIDX_W-1:0]          rd_addr,
  output logic signed [ppt_pkg::LAT_W-1:0]    rd_lat,
  output logic signed [ppt_pkg::LON_W-1:0]    rd_lon
);
  import ppt_pkg::*;

  logic signed [LAT_W-1:0] lat_mem [MAX_VERTICES];
  logic signed [LON_W-1:0] lon_mem [MAX_VERTICES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      lat_mem[wr_addr] <= wr_lat;
      lon_mem[wr_addr] <= wr_lon;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_lat <= lat_mem[rd_addr];
      rd_lon <= lon_mem[rd_addr];
    end
  end

endmodule

// ----- src/ppt_mac.sv -----
module ppt_mac (
  input  logic                            clk,
  input  ppt_pkg::mac_op_t                op,
  output logic signed [ppt_pkg::ACC_W-1:0] acc
);
  import ppt_pkg::*;

  logic [63:0]      prod;
  logic             p_valid;
  logic             p_clr;
  logic             p_neg;
  logic [1:0]       p_shift;
  logic [ACC_W-1:0] shifted;
  logic [ACC_W-1:0] term;

  always_ff @(posedge clk) begin
    prod    <= op.a * op.b;
    p_valid <= op.valid;
    p_clr   <= op.clr;
    p_neg   <= op.neg;
    p_shift <= op.shift;
  end

  assign shifted = ACC_W'(prod) << {p_shift, 5'b0};
  assign term    = p_neg ? (~shifted + ACC_W'(1)) : shifted;

  always_ff @(posedge clk) begin
    if (p_valid) begin
      acc <= p_clr ? $signed(term) : $signed(acc + term);
    end
  end

endmodule

// ----- src/polyline_proximity_test.sv -----
// channel | signals                                   | direction
// in      | in_valid, in_stall, action, lat/lon_udeg  | producer -> block
// out     | out_valid, out_stall, near, status, total | block -> consumer
// cfg     | cfg_wr_en, cfg_wr_data                    | host -> block
// A query walks the segments one after another; every product of a segment
// passes through the single 32x32 multiplier.
// rst is synchronous and clears the vertex count, sequencer and output valid.
// in_stall is high from accept until the result is loaded into the output
// register; a stalled output beat holds the next result in the sequencer.
module polyline_proximity_test (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [ppt_pkg::THR_W-1:0]           cfg_wr_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          action,
  input  logic signed [ppt_pkg::LAT_W-1:0]    lat_udeg,
  input  logic signed [ppt_pkg::LON_W-1:0]    lon_udeg,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                near,
  output logic                                status,
  output logic [ppt_pkg::CNT_W-1:0]           vertex_total
);
  import ppt_pkg::*;
  `include "polyline_proximity_test_defines.svh"

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_FETCH = 7'b0000010,
    S_LATCH = 7'b0000100,
    S_MAC   = 7'b0001000,
    S_DRAIN = 7'b0010000,
    S_EVAL  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t           state;
  phase_t           phase;
  logic [3:0]       step;
  logic [3:0]       last_step;
  logic [CNT_W-1:0] seg;
  logic [CNT_W-1:0] cnt;
  logic [THR_W-1:0] thr;

  logic signed [LAT_W-1:0] p_lat, a_lat, b_lat;
  logic signed [LON_W-1:0] p_lon, a_lon, b_lon;
  logic [LON_W-1:0]        adx, asx, aex;
  logic [LAT_W-1:0]        ady, asy, aey;
  logic                    sdx, sdy, ssx, ssy;
  logic [SQ_W-1:0]         d2, m, thr2;
  logic [N_W-1:0]          n;
  logic                    pend_near, pend_status;

  logic                    in_acc;
  logic                    wr_en;
  logic signed [LAT_W-1:0] rd_lat;
  logic signed [LON_W-1:0] rd_lon;
  logic signed [ACC_W-1:0] acc;
  mac_op_t                 op;

  logic signed [LON_W:0]   dlon, slon, elon;
  logic signed [LAT_W:0]   dlat, slat, elat;
  logic [N_W-1:0]          n_now;
  logic                    term;
  logic [1:0]              tsel;
  logic [1:0]              part;
  logic [63:0]             x64, y64;
  logic                    xneg;
  logic                    hit;
  logic                    hit_valid;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign wr_en    = in_acc && (action == ACT_APPEND) && (cnt < CNT_W'(MAX_VERTICES));

  ppt_vertex_store u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cnt[VIDX_W-1:0]),
    .wr_lat  (lat_udeg),
    .wr_lon  (lon_udeg),
    .rd_en   (state == S_FETCH),
    .rd_addr (seg[VIDX_W-1:0]),
    .rd_lat  (rd_lat),
    .rd_lon  (rd_lon)
  );

  ppt_mac u_mac (
    .clk (clk),
    .op  (op),
    .acc (acc)
  );

  // differences of p and the fresh vertex b from a, and of p from b
  assign dlon = {p_lon[LON_W-1], p_lon} - {a_lon[LON_W-1], a_lon};
  assign dlat = {p_lat[LAT_W-1], p_lat} - {a_lat[LAT_W-1], a_lat};
  assign slon = {rd_lon[LON_W-1], rd_lon} - {a_lon[LON_W-1], a_lon};
  assign slat = {rd_lat[LAT_W-1], rd_lat} - {a_lat[LAT_W-1], a_lat};
  assign elon = {p_lon[LON_W-1], p_lon} - {rd_lon[LON_W-1], rd_lon};
  assign elat = {p_lat[LAT_W-1], p_lat} - {rd_lat[LAT_W-1], rd_lat};

  assign n_now = acc[N_W-1:0];

  // operand selection for the shared multiplier
  always_comb begin
    part      = (phase == PH_W) ? step[1:0] : 2'd0;
    tsel      = (phase == PH_W) ? step[3:2] : {1'b0, step[0]};
    term      = step[0];
    x64       = '0;
    y64       = '0;
    xneg      = 1'b0;
    last_step = 4'd1;
    unique case (phase)
      PH_T: begin
        x64       = 64'(thr);
        y64       = 64'(thr);
        last_step = 4'd0;
      end
      PH_D2: begin
        x64 = term ? 64'(ady) : 64'(adx);
        y64 = x64;
      end
      PH_M: begin
        x64 = term ? 64'(asy) : 64'(asx);
        y64 = x64;
      end
      PH_N: begin
        x64  = term ? 64'(ady) : 64'(adx);
        y64  = term ? 64'(asy) : 64'(asx);
        xneg = term ? (sdy ^ ssy) : (sdx ^ ssx);
      end
      PH_E: begin
        x64 = term ? 64'(aey) : 64'(aex);
        y64 = x64;
      end
      PH_W: begin
        last_step = 4'd11;
        case (tsel)
          2'd0: begin
            x64 = 64'(d2);
            y64 = 64'(m);
          end
          2'd1: begin
            x64  = 64'(thr2);
            y64  = 64'(m);
            xneg = 1'b1;
          end
          default: begin
            x64  = 64'(n[SQ_W-1:0]);
            y64  = 64'(n[SQ_W-1:0]);
            xneg = 1'b1;
          end
        endcase
      end
      default: begin
        x64 = '0;
      end
    endcase
    op.valid = (state == S_MAC);
    op.clr   = (step == 4'd0);
    op.neg   = xneg;
    op.shift = {1'b0, part[1]} + {1'b0, part[0]};
    op.a     = part[1] ? x64[63:32] : x64[31:0];
    op.b     = part[0] ? y64[63:32] : y64[31:0];
  end

  // segment verdict in EVAL
  always_comb begin
    hit       = 1'b0;
    hit_valid = 1'b0;
    case (phase)
      PH_N: begin
        if ((m == '0) || n_now[N_W-1] || (n_now == '0)) begin
          hit       = (d2 <= thr2);
          hit_valid = 1'b1;
        end
      end
      PH_E: begin
        hit       = (acc[SQ_W-1:0] <= thr2);
        hit_valid = 1'b1;
      end
      PH_W: begin
        hit       = acc[ACC_W-1] || (acc == '0);
        hit_valid = 1'b1;
      end
      default: begin
        hit_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_W'(9);
    end else if (cfg_wr_en) begin
      thr <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cnt         <= '0;
      seg         <= '0;
      step        <= '0;
      phase       <= PH_T;
      pend_near   <= 1'b0;
      pend_status <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            pend_near   <= 1'b0;
            pend_status <= 1'b0;
            p_lat       <= lat_udeg;
            p_lon       <= lon_udeg;
            state       <= S_OUT;
            case (action)
              ACT_CLEAR: cnt <= '0;
              ACT_APPEND: begin
                if (cnt < CNT_W'(MAX_VERTICES)) begin
                  cnt <= cnt + CNT_W'(1);
                end else begin
                  pend_status <= 1'b1;
                end
              end
              ACT_QUERY: begin
                if (cnt >= CNT_W'(2)) begin
                  seg   <= '0;
                  state <= S_FETCH;
                end
              end
              default: state <= S_OUT;
            endcase
          end
        end
        S_FETCH: state <= S_LATCH;
        S_LATCH: begin
          step  <= '0;
          state <= S_MAC;
          if (seg == '0) begin
            a_lat <= rd_lat;
            a_lon <= rd_lon;
            seg   <= CNT_W'(1);
            phase <= PH_T;
          end else begin
            b_lat <= rd_lat;
            b_lon <= rd_lon;
            sdx   <= dlon[LON_W];
            sdy   <= dlat[LAT_W];
            ssx   <= slon[LON_W];
            ssy   <= slat[LAT_W];
            adx   <= dlon[LON_W] ? LON_W'(-dlon) : dlon[LON_W-1:0];
            ady   <= dlat[LAT_W] ? LAT_W'(-dlat) : dlat[LAT_W-1:0];
            asx   <= slon[LON_W] ? LON_W'(-slon) : slon[LON_W-1:0];
            asy   <= slat[LAT_W] ? LAT_W'(-slat) : slat[LAT_W-1:0];
            aex   <= elon[LON_W] ? LON_W'(-elon) : elon[LON_W-1:0];
            aey   <= elat[LAT_W] ? LAT_W'(-elat) : elat[LAT_W-1:0];
            phase <= PH_D2;
          end
        end
        S_MAC: begin
          step <= step + 4'd1;
          if (step == last_step) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: state <= S_EVAL;
        S_EVAL: begin
          step  <= '0;
          state <= S_MAC;
          case (phase)
            PH_T: begin
              thr2  <= acc[SQ_W-1:0];
              state <= S_FETCH;
            end
            PH_D2: begin
              d2    <= acc[SQ_W-1:0];
              phase <= PH_M;
            end
            PH_M: begin
              m     <= acc[SQ_W-1:0];
              phase <= PH_N;
            end
            PH_N: begin
              n <= n_now;
              if (!hit_valid) begin
                phase <= (n_now[SQ_W-1:0] >= m) ? PH_E : PH_W;
              end
            end
            default: state <= S_MAC;
          endcase
          if (hit_valid) begin
            if (hit) begin
              pend_near <= 1'b1;
              state     <= S_OUT;
            end else begin
              a_lat <= b_lat;
              a_lon <= b_lon;
              if (seg + CNT_W'(1) == cnt) begin
                state <= S_OUT;
              end else begin
                seg   <= seg + CNT_W'(1);
                state <= S_FETCH;
              end
            end
          end
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_OUT) && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_OUT) && (!out_valid || !out_stall)) begin
      near         <= pend_near;
      status       <= pend_status;
      vertex_total <= cnt;
    end
  end

  `PPT_ASSERT_IMPL(a_cnt_max, clk, rst, 1'b1, cnt <= CNT_W'(MAX_VERTICES), "count too large")
  `PPT_ASSERT_IMPL(a_excl, clk, rst, out_valid, !(near && status), "near and status both set")
  `PPT_ASSERT_NEXT(a_busy, clk, rst, in_acc, state != S_IDLE, "accept did not start work")
  `PPT_ASSERT_IMPL(a_seg, clk, rst, state == S_EVAL, seg < cnt, "segment index past table")

endmodule

// ----- verif/tb_polyline_proximity_test.sv -----
module tb_polyline_proximity_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ppt_pkg::*;

  localparam logic [1:0] ACT_IGNORED = 2'd3;
  localparam int STALL_STRETCH = 2000;
  localparam int QUIET_LIMIT = 20000;

  typedef struct {
    logic [1:0]              act;
    logic signed [LAT_W-1:0] lat;
    logic signed [LON_W-1:0] lon;
  } beat_t;

  typedef struct {
    logic             near;
    logic             status;
    logic [CNT_W-1:0] total;
  } verdict_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_wr_en = 0;
  logic [THR_W-1:0] cfg_wr_data = '0;
  logic in_valid = 0;
  logic in_stall;
  logic [1:0] action = '0;
  logic signed [LAT_W-1:0] lat_udeg = '0;
  logic signed [LON_W-1:0] lon_udeg = '0;
  logic out_valid;
  logic out_stall = 0;
  logic near;
  logic status;
  logic [CNT_W-1:0] vertex_total;

  polyline_proximity_test i_dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .lat_udeg(lat_udeg), .lon_udeg(lon_udeg),
    .out_valid(out_valid), .out_stall(out_stall),
    .near(near), .status(status), .vertex_total(vertex_total)
  );

  beat_t    pending_beats[$];
  verdict_t expected_verdicts[$];
  int       errors = 0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  logic     hold_req = 0;
  logic     hold_done = 0;
  int       hold_cnt = 0;
  int       quiet_cycles = 0;

  // shadow of the polyline and threshold
  logic signed [LAT_W-1:0] poly_lat[MAX_VERTICES];
  logic signed [LON_W-1:0] poly_lon[MAX_VERTICES];
  int unsigned poly_count = 0;
  logic [THR_W-1:0] near_limit = 29'd9;

  function automatic logic segment_near(input int unsigned i, input beat_t b);
    logic signed [127:0] py, px, ay, ax, by, bx, dy, dx, sy, sx, m, d2, n, e2, t2;
    py = b.lat; px = b.lon;
    ay = poly_lat[i-1]; ax = poly_lon[i-1];
    by = poly_lat[i];   bx = poly_lon[i];
    dy = py - ay; dx = px - ax; sy = by - ay; sx = bx - ax;
    t2 = near_limit;
    t2 = t2 * t2;
    m = sx * sx + sy * sy;
    d2 = dx * dx + dy * dy;
    if (m == 0) return d2 <= t2;
    n = dx * sx + dy * sy;
    if (n <= 0) return d2 <= t2;
    if (n >= m) begin
      e2 = (px - bx) * (px - bx) + (py - by) * (py - by);
      return e2 <= t2;
    end
    return d2 * m <= t2 * m + n * n;
  endfunction

  function automatic verdict_t polyline_verdict(input beat_t b);
    verdict_t v;
    v.near = 0;
    v.status = 0;
    if (b.act == ACT_CLEAR) begin
      poly_count = 0;
    end else if (b.act == ACT_APPEND) begin
      if (poly_count < MAX_VERTICES) begin
        poly_lat[poly_count] = b.lat;
        poly_lon[poly_count] = b.lon;
        poly_count++;
      end else begin
        v.status = 1;
      end
    end else if (b.act == ACT_QUERY) begin
      for (int unsigned i = 1; i < poly_count; i++) begin
        if (segment_near(i, b)) begin
          v.near = 1;
          break;
        end
      end
    end
    v.total = CNT_W'(poly_count);
    return v;
  endfunction

  function automatic beat_t mk(input logic [1:0] a, input int la, input int lo);
    beat_t b;
    b.act = a;
    b.lat = LAT_W'(la);
    b.lon = LON_W'(lo);
    return b;
  endfunction

  function automatic void queue_beat(input beat_t b);
    pending_beats.insert(pending_beats.size(), b);
  endfunction

  initial begin
    forever #4 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin
    beat_t b;
    if (rst) begin
      in_valid <= 0;
    end else begin
      if (in_valid && !in_stall)
        expected_verdicts.insert(expected_verdicts.size(),
                                 polyline_verdict(mk(action, lat_udeg, lon_udeg)));
      if (!in_valid || !in_stall) begin
        if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          b = pending_beats.pop_front();
          action <= b.act;
          lat_udeg <= b.lat;
          lon_udeg <= b.lon;
          in_valid <= 1;
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    verdict_t v;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_verdicts.size() == 0) begin
          $error("unexpected result beat: near %0d status %0d total %0d",
                 near, status, vertex_total);
          errors++;
        end else begin
          v = expected_verdicts.pop_front();
          if (near !== v.near) begin
            $error("near: expected %0d, actual %0d", v.near, near);
            errors++;
          end
          if (status !== v.status) begin
            $error("status: expected %0d, actual %0d", v.status, status);
            errors++;
          end
          if (vertex_total !== v.total) begin
            $error("vertex_total: expected %0d, actual %0d", v.total, vertex_total);
            errors++;
          end
        end
      end
      if (hold_req && !hold_done) begin
        out_stall <= 1;
        if (hold_cnt == STALL_STRETCH) hold_done <= 1;
        hold_cnt <= hold_cnt + 1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("polyline_proximity_test regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic drain();
    while (pending_beats.size() != 0 || in_valid || expected_verdicts.size() != 0)
      @(negedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_limit(input logic [THR_W-1:0] v);
    drain();
    @(posedge clk);
    cfg_wr_en <= 1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 0;
    near_limit = v;
  endtask

  task automatic random_phase(input int n_items);
    int cnt, nv, nq, sp, clat, clon, k;
    cnt = 0;
    while (cnt < n_items) begin
      if ($urandom_range(9) < 8) begin
        nv = ($urandom_range(19) == 0) ? $urandom_range(60, 66) : $urandom_range(0, 8);
        sp = 1 << $urandom_range(2, 20);
        clat = $urandom_range(0, 180000000) - 90000000;
        clon = $urandom_range(0, 360000000) - 180000000;
        queue_beat(mk(ACT_CLEAR, $urandom, $urandom));
        for (int i = 0; i < nv; i++)
          queue_beat(mk(ACT_APPEND,
            clat + int'($urandom_range(0, 2 * sp)) - sp,
            clon + int'($urandom_range(0, 2 * sp)) - sp));
        nq = $urandom_range(1, 5);
        for (int i = 0; i < nq; i++) begin
          k = sp >> $urandom_range(0, 8);
          queue_beat(mk(ACT_QUERY,
            clat + int'($urandom_range(0, 2 * k + 2)) - k,
            clon + int'($urandom_range(0, 2 * k + 2)) - k));
        end
        cnt += 1 + nv + nq;
      end else begin
        queue_beat(mk(2'($urandom_range(3)), $urandom, $urandom));
        cnt++;
      end
    end
  endtask

  initial begin
    logic [THR_W-1:0] limits[5];
    limits = '{29'd4096, 29'd0, 29'd360000000, 29'h1FFFFFFF, 29'd1};
    repeat (9) @(posedge clk);
    rst <= 0;

    // directed, reset threshold of 9
    queue_beat(mk(ACT_CLEAR, 0, 0));
    queue_beat(mk(ACT_QUERY, 0, 0));
    queue_beat(mk(ACT_APPEND, 100, 100));
    queue_beat(mk(ACT_QUERY, 100, 100));
    queue_beat(mk(ACT_APPEND, 100, 100));
    queue_beat(mk(ACT_QUERY, 109, 100));
    queue_beat(mk(ACT_QUERY, 107, 107));
    queue_beat(mk(ACT_APPEND, 100, 200));
    queue_beat(mk(ACT_QUERY, 109, 150));
    queue_beat(mk(ACT_QUERY, 110, 150));
    queue_beat(mk(ACT_QUERY, 100, 91));
    queue_beat(mk(ACT_QUERY, 100, 209));
    queue_beat(mk(ACT_QUERY, 100, 210));
    queue_beat(mk(ACT_IGNORED, -1, -1));
    queue_beat(mk(ACT_CLEAR, 0, 0));
    queue_beat(mk(ACT_APPEND, -(1 << 27), -(1 << 28)));
    queue_beat(mk(ACT_APPEND, (1 << 27) - 1, (1 << 28) - 1));
    queue_beat(mk(ACT_QUERY, -(1 << 27), (1 << 28) - 1));
    queue_beat(mk(ACT_QUERY, 0, 0));
    queue_beat(mk(ACT_APPEND, -(1 << 27), (1 << 28) - 1));
    queue_beat(mk(ACT_QUERY, (1 << 27) - 1, -(1 << 28)));
    queue_beat(mk(ACT_IGNORED, 0, 0));

    for (int p = 0; p < 5; p++) begin
      set_limit(limits[p]);
      send_idle_pct <= (p % 4 == 1) ? 82 : (p % 4 == 3) ? 18 : 0;
      recv_stall_pct <= (p % 4 == 2) ? 82 : (p % 4 == 3) ? 18 : 0;
      if (p == 0) hold_req <= 1;
      random_phase(230);
    end
    drain();
    if (errors == 0)
      $display("polyline_proximity_test regression: pass");
    else
      $display("polyline_proximity_test regression: fail");
    $finish;
  end
endmodule

// ----- filelist.f -----
+incdir+src
src/ppt_pkg.sv
src/ppt_vertex_store.sv
src/ppt_mac.sv
src/polyline_proximity_test.sv
verif/tb_polyline_proximity_test.sv
